FILE: hw/rtl/frp_pkg.sv
// Shared types, constants and a helper function for the FASTQ record packer.
`default_nettype none
package frp_pkg;

  // Field widths of the stream payloads and configuration registers
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int REC_W       = 24;
  localparam int POS_W       = 6;
  localparam int BASE_W      = 2;
  localparam int QUAL_W      = 6;
  localparam int STAT_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 24;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_PAD_W   = 2;
  localparam int OUT_TDATA_W = BYTE_W + POS_W + REC_W + OUT_PAD_W;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_AT     = 8'h40;
  localparam logic [BYTE_W-1:0] CHAR_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] QUAL_OFFSET = 8'd33;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DATA    = 3'd0,
    STAT_BAD_HDR = 3'd1,
    STAT_LEN     = 3'd2,
    STAT_EARLY   = 3'd3,
    STAT_FEW     = 3'd4
  } status_t;

  // Line within a four-line record
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SEQ    = 2'd1,
    PH_SEP    = 2'd2,
    PH_QUAL   = 2'd3
  } phase_t;

  // Controller state
  typedef enum logic {
    CTRL_PARSE,
    CTRL_DRAIN
  } ctrl_state_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_LENGTH   = 1'b0,
    REG_CLUSTER_COUNT = 1'b1
  } cfg_reg_t;

  // Base codes for bytes 0x40..0x5F, lower case folds onto the same entries
  localparam logic [BASE_W-1:0] BASE_TAB [32] = '{
    2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd2,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  // Control broadcast from the controller to every cell
  typedef struct packed {
    logic              wr_seq;
    logic              wr_qual;
    logic              shift;
    logic [POS_W-1:0]  wr_pos;
    logic [BASE_W-1:0] base;
    logic [QUAL_W-1:0] qual;
  } cell_ctrl_t;

  function automatic logic [BASE_W-1:0] base_code(input logic [BYTE_W-1:0] b);
    logic [BASE_W-1:0] code;
    code = '0;
    if (b[7:6] == 2'b01) begin
      code = BASE_TAB[b[4:0]];
    end
    return code;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/frp_cell.sv
// One position cell: holds base and quality of one read position, shifts toward the head.
`default_nettype none
module frp_cell #(
  parameter int CELL_POS = 0
) (
  input  wire logic                      clk,
  input  wire frp_pkg::cell_ctrl_t       ctrl,
  input  wire logic [frp_pkg::BASE_W-1:0] next_base,
  input  wire logic [frp_pkg::QUAL_W-1:0] next_qual,
  output logic      [frp_pkg::BASE_W-1:0] base,
  output logic      [frp_pkg::QUAL_W-1:0] qual
);
  import frp_pkg::*;

  logic hit;

  assign hit = (ctrl.wr_pos == POS_W'(CELL_POS));

  // Shift during drain, else capture own position while a line streams in
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      base <= next_base;
      qual <= next_qual;
    end else begin
      if (ctrl.wr_seq && hit) begin
        base <= ctrl.base;
      end
      if (ctrl.wr_qual && hit) begin
        qual <= ctrl.qual;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/frp_ctrl.sv
// Line parser, record checker, drain sequencer and output register.
`default_nettype none
module frp_ctrl #(
  parameter int MAX_READ_LEN = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [frp_pkg::IN_TDATA_W-1:0] s_tdata,
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [frp_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic      [frp_pkg::STAT_W-1:0]     m_tuser,
  output logic                                m_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [frp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [frp_pkg::CFG_W-1:0]      cfg_data,
  output frp_pkg::cell_ctrl_t                 cell_ctrl,
  input  wire logic [frp_pkg::BASE_W-1:0]     head_base,
  input  wire logic [frp_pkg::QUAL_W-1:0]     head_qual
);
  import frp_pkg::*;

  localparam int CNT_W = $clog2(MAX_READ_LEN + 1);

  // Control registers
  ctrl_state_t       state, state_next;
  phase_t            phase, phase_next;
  logic              at_start, at_start_next;
  logic [CNT_W-1:0]  column, column_next;
  logic [LEN_W-1:0]  learned, learned_next;
  logic [REC_W-1:0]  cluster;
  logic [REC_W-1:0]  records, records_next;
  logic              err_stuck, err_next;
  logic [CNT_W-1:0]  drain_pos, drain_pos_next;

  // Output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_packed;
  logic [POS_W-1:0]  out_pos;
  logic [REC_W-1:0]  out_rec;
  status_t           out_status;
  logic              out_last;

  logic              out_free, s_fire, ignore;
  logic [BYTE_W-1:0] in_byte;
  logic              err_load, drain_start, drain_load, drain_last;
  status_t           err_code;
  logic              len_bad;

  assign out_free = !out_valid || m_tready;
  assign s_tready = !rst && (state == CTRL_PARSE) && out_free;
  assign s_fire   = s_tvalid && s_tready;
  assign in_byte  = s_tdata[BYTE_W-1:0];
  assign ignore   = err_stuck || (records >= cluster);
  assign len_bad  = (LEN_W'(column) != learned);
  assign drain_last = ((LEN_W'(drain_pos) + LEN_W'(1)) == learned);

  // Parse one beat and sequence the drain
  always_comb begin
    phase_next     = phase;
    at_start_next  = at_start;
    column_next    = column;
    learned_next   = learned;
    records_next   = records;
    err_next       = err_stuck;
    drain_pos_next = drain_pos;
    err_load       = 1'b0;
    err_code       = STAT_DATA;
    drain_start    = 1'b0;
    drain_load     = 1'b0;
    cell_ctrl      = '0;
    cell_ctrl.wr_pos = POS_W'(column);
    cell_ctrl.base   = base_code(in_byte);
    cell_ctrl.qual   = QUAL_W'(in_byte - QUAL_OFFSET);

    if (s_fire && !ignore) begin
      priority if (s_tuser) begin
        err_load = 1'b1;
        err_code = (phase == PH_HEADER && at_start) ? STAT_FEW : STAT_EARLY;
      end else if (at_start && ((phase == PH_HEADER && in_byte != CHAR_AT) ||
                                (phase == PH_SEP && in_byte != CHAR_PLUS))) begin
        err_load = 1'b1;
        err_code = STAT_BAD_HDR;
      end else if (in_byte != CHAR_LF) begin
        at_start_next = 1'b0;
        if (phase == PH_SEQ || phase == PH_QUAL) begin
          if (column == CNT_W'(MAX_READ_LEN)) begin
            err_load = 1'b1;
            err_code = STAT_LEN;
          end else begin
            cell_ctrl.wr_seq  = (phase == PH_SEQ);
            cell_ctrl.wr_qual = (phase == PH_QUAL);
            column_next       = column + CNT_W'(1);
          end
        end
      end else begin
        unique case (phase)
          PH_SEQ: begin
            if (learned != '0 && len_bad) begin
              err_load = 1'b1;
              err_code = STAT_LEN;
            end else begin
              if (learned == '0) begin
                learned_next = LEN_W'(column);
              end
              phase_next    = PH_SEP;
              at_start_next = 1'b1;
              column_next   = '0;
            end
          end
          PH_QUAL: begin
            if (len_bad) begin
              err_load = 1'b1;
              err_code = STAT_LEN;
            end else begin
              phase_next    = PH_HEADER;
              at_start_next = 1'b1;
              column_next   = '0;
              // empty read emits nothing but still counts as a record
              if (learned == '0) begin
                records_next = records + REC_W'(1);
              end else begin
                drain_start    = 1'b1;
                drain_pos_next = '0;
              end
            end
          end
          default: begin
            phase_next    = phase_t'(phase + 2'd1);
            at_start_next = 1'b1;
            column_next   = '0;
          end
        endcase
      end
    end

    if (err_load) begin
      err_next = 1'b1;
    end

    // Drain one position per free output slot
    if (state == CTRL_DRAIN && out_free) begin
      drain_load      = 1'b1;
      cell_ctrl.shift = 1'b1;
      if (drain_last) begin
        records_next = records + REC_W'(1);
      end else begin
        drain_pos_next = drain_pos + CNT_W'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CTRL_PARSE: if (drain_start) state_next = CTRL_DRAIN;
      CTRL_DRAIN: if (drain_load && drain_last) state_next = CTRL_PARSE;
      default:    state_next = CTRL_PARSE;
    endcase
  end

  // Control registers and configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTRL_PARSE;
      phase     <= PH_HEADER;
      at_start  <= 1'b1;
      column    <= '0;
      learned   <= '0;
      cluster   <= '0;
      records   <= '0;
      err_stuck <= 1'b0;
      drain_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      at_start  <= at_start_next;
      column    <= column_next;
      records   <= records_next;
      err_stuck <= err_next;
      drain_pos <= drain_pos_next;
      if (err_load || drain_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      // a read length write also reloads the learned length
      if (cfg_we && cfg_reg_t'(cfg_index) == REG_READ_LENGTH) begin
        learned <= cfg_data[LEN_W-1:0];
      end else begin
        learned <= learned_next;
      end
      if (cfg_we && cfg_reg_t'(cfg_index) == REG_CLUSTER_COUNT) begin
        cluster <= cfg_data[REC_W-1:0];
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (err_load) begin
      out_packed <= '0;
      out_pos    <= '0;
      out_rec    <= records;
      out_status <= err_code;
      out_last   <= 1'b1;
    end else if (drain_load) begin
      out_packed <= {head_qual, head_base};
      out_pos    <= POS_W'(drain_pos);
      out_rec    <= records;
      out_status <= STAT_DATA;
      out_last   <= drain_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_rec, out_pos, out_packed};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

FILE: hw/rtl/fastq_record_packer_core.sv
// A quality-line newline enters the drain state; the first result beat is then registered.
// Throughput: one text byte per cycle while no drain runs and the output is free; each
// non-empty record then drains one position per cycle through the cell chain while the
// output is free. Errors give one beat in the cycle after the offending beat, then stick.
// Reset: synchronous active-high rst clears control state; read length and record
// count read as zero and position cells hold no defined data until written.
`default_nettype none
module fastq_record_packer_core #(
  parameter int MAX_READ_LEN = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [frp_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
  input  wire logic                            s_tuser,   // [0] end_of_stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [7:0] packed_value, [13:8] position_index, [37:14] record_index, [39:38] zero
  output logic      [frp_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic      [frp_pkg::STAT_W-1:0]      m_tuser,   // [2:0] status
  output logic                                 m_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [frp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frp_pkg::CFG_W-1:0]       cfg_data
);
  import frp_pkg::*;

  cell_ctrl_t        cell_ctrl;
  logic [BASE_W-1:0] cell_base [MAX_READ_LEN];
  logic [QUAL_W-1:0] cell_qual [MAX_READ_LEN];

  frp_ctrl #(
    .MAX_READ_LEN(MAX_READ_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_ctrl (cell_ctrl),
    .head_base (cell_base[0]),
    .head_qual (cell_qual[0])
  );

  // Row of position cells, cell 0 at the output end
  for (genvar i = 0; i < MAX_READ_LEN; i++) begin : g_cell
    logic [BASE_W-1:0] nb;
    logic [QUAL_W-1:0] nq;
    if (i == MAX_READ_LEN - 1) begin : g_tail
      assign nb = '0;
      assign nq = '0;
    end else begin : g_body
      assign nb = cell_base[i+1];
      assign nq = cell_qual[i+1];
    end
    frp_cell #(
      .CELL_POS(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .next_base (nb),
      .next_qual (nq),
      .base      (cell_base[i]),
      .qual      (cell_qual[i])
    );
  end

endmodule
`default_nettype wire

FILE: hw/rtl/frp_checker.sv
// Port-level checker for the FASTQ record packer, bound to the top level.
`default_nettype none
module frp_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [frp_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic [frp_pkg::STAT_W-1:0]      m_tuser,
  input wire logic                            m_tlast
);
  import frp_pkg::*;

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // No input taken while a result is stuck
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid && !m_tready))
    else $error("input accepted while output stalled");

  // Error beats are single, have zero packed value and position, and close the run
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STAT_DATA |-> m_tlast && m_tdata[13:0] == 14'd0)
    else $error("malformed error beat");

  // Nothing follows an error beat
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser != STAT_DATA |=> !m_tvalid)
    else $error("result after error");

  // A drained record streams positions back to back
  a_drain_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == STAT_DATA && !m_tlast |=>
      m_tvalid && m_tuser == STAT_DATA &&
      m_tdata[13:8] == 6'($past(m_tdata[13:8]) + 6'd1))
    else $error("drain position sequence broken");

endmodule

bind fastq_record_packer_core frp_checker u_frp_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);
`default_nettype wire
